// ----- sv/sfhc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfhc_pkg
// Shared constants and types for the sphere frustum / horizon cull core.
// ----------------------------------------------------------------------------
package sfhc_pkg;

  localparam int unsigned NUM_PLANES_DEF       = 5;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 30;
  localparam int unsigned CFG_IDX_W            = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBE_MIN_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_DIST_SQ   = 3'd5;

  // Square root unit control
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] root;   // rounded up, up to 2^32
  } sqrt_rsp_t;

endpackage

// ----- sv/sfhc_sqrt.sv -----
// ----------------------------------------------------------------------------
// sfhc_sqrt
// Iterative 64-bit integer square root, one result bit per cycle, rounded up.
// ----------------------------------------------------------------------------
module sfhc_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  sfhc_pkg::sqrt_req_t req,
  output sfhc_pkg::sqrt_rsp_t rsp
);

  logic [63:0] rad_r;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  pair;
  logic [65:0] trial;

  // next two radicand bits, from the top down
  assign pair = rad_r[{step_r[4:0], 1'b1} -: 2];

  always_comb begin
    // bring down two radicand bits, try root*4+1
    trial    = {rem_r, pair} - {32'd0, root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = 6'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[65]) begin
        rem_nxt  = trial[63:0];
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[61:0], pair};
        root_nxt = {root_r[30:0], 1'b0};
      end
      if (step_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    if (req.start) rad_r <= req.radicand;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  // nonzero remainder means the radicand was not a perfect square: round up
  assign rsp.done = done_r;
  assign rsp.root = {1'b0, root_r} + {32'd0, (rem_r != 64'd0)};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("sqrt done held for two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("sqrt done while busy");

endmodule

// ----- sv/sfhc_mac.sv -----
// ----------------------------------------------------------------------------
// sfhc_mac
// Shared signed 33x33 multiplier with a registered product and a 128-bit
// accumulator.
// ----------------------------------------------------------------------------
module sfhc_mac (
  input  logic                 clk,
  input  logic signed [32:0]   a,
  input  logic signed [32:0]   b,
  input  logic                 mul_en,
  input  logic                 acc_clr,
  input  logic                 acc_en,
  output logic signed [65:0]   prod,
  output logic signed [127:0]  acc
);

  logic signed [65:0]  prod_r;
  logic signed [127:0] acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (acc_clr)     acc_nxt = '0;
    else if (acc_en) acc_nxt = acc_r + {{62{prod_r[65]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= a * b;
    acc_r <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ----- sv/sphere_frustum_horizon_cull_core.sv -----
// ----------------------------------------------------------------------------
// sphere_frustum_horizon_cull_core
// Sphere cull against stored frustum planes and a globe horizon occluder.
// ----------------------------------------------------------------------------
// A plane load (kind 0) writes one plane slot and returns no item; a load to
// a slot at or above NUM_PLANES is dropped. A sphere test (kind 1) returns one
// item with two flags, and the next item can be taken from the cycle in
// which that item is offered. Each plane costs a store read, four
// product/accumulate pairs on the single shared multiply-accumulate unit and
// a compare; the occluder square is issued on the multiplier and checked in
// the next state; the two rounded-up square roots run one after another on
// one bit-serial root unit; the square of their sum takes a 34-step
// shift-add; the three terms of the squared camera distance are issued on the
// multiplier and summed, and a final compare follows. A negative radius goes
// from the first store read straight to the output, a plane that already
// culls the sphere skips the remaining planes, and an occluder that vanishes
// skips the horizon test. The block takes one item at a time; in_ready is low
// from acceptance until the result item is handed off to the output register.
// The plane store is undefined until written. Configuration writes are taken
// at any time and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module sphere_frustum_horizon_cull_core #(
  parameter int unsigned NUM_PLANES       = sfhc_pkg::NUM_PLANES_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = sfhc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [2:0]  in_plane_index,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_sphere_radius,
  input  logic [63:0] in_center_dist_sq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_outside_frustum,
  output logic        out_beyond_horizon
);

  localparam int unsigned PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PRD   = 4'd1;  // plane store read latency
  localparam logic [3:0] ST_MUL   = 4'd2;  // issue one product
  localparam logic [3:0] ST_ACC   = 4'd3;  // accumulate it
  localparam logic [3:0] ST_PCMP  = 4'd4;  // compare plane sum
  localparam logic [3:0] ST_OCC   = 4'd5;  // occluder square
  localparam logic [3:0] ST_OCHK  = 4'd6;
  localparam logic [3:0] ST_SQ1   = 4'd7;
  localparam logic [3:0] ST_SQ2   = 4'd8;
  localparam logic [3:0] ST_TSQ   = 4'd9;  // t*t
  localparam logic [3:0] ST_DIST  = 4'd10; // squared distance terms
  localparam logic [3:0] ST_HCMP  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;
  localparam logic [3:0] ST_LOAD  = 4'd13;

  // configuration registers
  logic [30:0]        globe_r, slack_r;
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [63:0]        cam_dsq_r;

  // plane store: one write port, one registered read port
  logic [127:0]      plane_mem [NUM_PLANES];
  logic [127:0]      plane_rd_r;
  logic [PIDX_W-1:0] pl_r;

  // captured item
  logic [3:0]         st_r;
  logic               kind_r;
  logic [2:0]         pidx_r;
  logic [127:0]       pdata_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [32:0] grown_r;
  logic               neg_r;
  logic [63:0]        dsq_r;
  logic [1:0]         term_r;
  logic               outside_r, hidden_r;
  logic signed [32:0] occ_r;
  logic [63:0]        occsq_r;
  logic [33:0]        t_r;
  logic               wait_r;
  logic               res_ovalid_r, res_out_r, res_hid_r;
  logic [127:0]       tsq_r;

  // shared multiplier operands
  logic signed [32:0]  mul_a, mul_b;
  logic                mul_en, acc_clr, acc_en;
  logic signed [65:0]  mul_prod;
  logic signed [127:0] acc;

  // square root unit
  sfhc_pkg::sqrt_req_t sq_req;
  sfhc_pkg::sqrt_rsp_t sq_rsp;

  // limit = -grown * 2^F
  logic signed [127:0] limit;

  // t squared by shift-add over its 34 bits
  logic [5:0]   tb_r;
  logic [127:0] prod_bits;

  // squared distance: products land in the cycle after issue
  logic [127:0] dacc_r;
  logic         dacc_clr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      globe_r   <= '0;
      slack_r   <= '0;
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= '0;
      cam_dsq_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfhc_pkg::REG_GLOBE_MIN_RADIUS: globe_r   <= cfg_data[30:0];
        sfhc_pkg::REG_SLACK:            slack_r   <= cfg_data[30:0];
        sfhc_pkg::REG_CAMERA_X:         cam_x_r   <= cfg_data[31:0];
        sfhc_pkg::REG_CAMERA_Y:         cam_y_r   <= cfg_data[31:0];
        sfhc_pkg::REG_CAMERA_Z:         cam_z_r   <= cfg_data[31:0];
        sfhc_pkg::REG_CAMERA_DIST_SQ:   cam_dsq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wire accept = in_valid && in_ready;
  // a waiting result sits in the output register and does not hold the input
  assign in_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (st_r == ST_LOAD && {1'b0, pidx_r} < 4'(NUM_PLANES))
      plane_mem[pidx_r[PIDX_W-1:0]] <= pdata_r;
    plane_rd_r <= plane_mem[pl_r];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_MUL: begin
        unique case (term_r)
          2'd0: begin mul_a = 33'(signed'(plane_rd_r[127:96])); mul_b = 33'(cx_r); end
          2'd1: begin mul_a = 33'(signed'(plane_rd_r[95:64]));  mul_b = 33'(cy_r); end
          2'd2: begin mul_a = 33'(signed'(plane_rd_r[63:32]));  mul_b = 33'(cz_r); end
          default: begin
            mul_a = 33'(signed'(plane_rd_r[31:0]));
            mul_b = 33'sd1 <<< NORMAL_FRAC_BITS;
          end
        endcase
      end
      ST_OCC: begin mul_a = occ_r; mul_b = occ_r; end
      ST_DIST: begin
        unique case (term_r)
          2'd0:    begin mul_a = 33'(cx_r) - 33'(cam_x_r); end
          2'd1:    begin mul_a = 33'(cy_r) - 33'(cam_y_r); end
          default: begin mul_a = 33'(cz_r) - 33'(cam_z_r); end
        endcase
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // t can reach 2^33 and does not fit the signed multiplier: square it by
  // shift-add below.
  assign mul_en  = (st_r == ST_MUL) || (st_r == ST_OCC) || (st_r == ST_DIST);
  assign acc_en  = (st_r == ST_ACC);
  assign acc_clr = (st_r == ST_PRD);

  sfhc_mac u_mac (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .mul_en  (mul_en),
    .acc_clr (acc_clr),
    .acc_en  (acc_en),
    .prod    (mul_prod),
    .acc     (acc)
  );

  always_comb begin
    sq_req.start    = 1'b0;
    sq_req.radicand = cam_dsq_r - occsq_r;
    if (st_r == ST_SQ1 && !wait_r) sq_req.start = 1'b1;
    if (st_r == ST_SQ2 && !wait_r) begin
      sq_req.start    = 1'b1;
      sq_req.radicand = dsq_r - occsq_r;
    end
  end

  sfhc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign limit = -(128'(grown_r) <<< NORMAL_FRAC_BITS);

  assign prod_bits = {94'd0, t_r} << tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      res_ovalid_r <= 1'b0;
      wait_r       <= 1'b0;
    end else begin
      if (res_ovalid_r && out_ready) res_ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r  <= in_kind;
            pidx_r  <= in_plane_index;
            pdata_r <= {in_normal_x, in_normal_y, in_normal_z, in_plane_offset};
            cx_r    <= in_center_x;
            cy_r    <= in_center_y;
            cz_r    <= in_center_z;
            dsq_r   <= in_center_dist_sq;
            neg_r   <= in_sphere_radius[31];
            grown_r <= 33'(in_sphere_radius) + 33'({1'b0, slack_r});
            outside_r <= 1'b0;
            hidden_r  <= 1'b0;
            pl_r      <= '0;
            st_r      <= in_kind ? ST_PRD : ST_LOAD;
          end
        end
        ST_LOAD: st_r <= ST_IDLE;
        ST_PRD: begin
          if (neg_r) st_r <= ST_OUT;
          else begin
            term_r <= 2'd0;
            st_r   <= ST_MUL;
          end
        end
        ST_MUL: st_r <= ST_ACC;
        ST_ACC: begin
          if (term_r == 2'd3) st_r <= ST_PCMP;
          else begin
            term_r <= term_r + 2'd1;
            st_r   <= ST_MUL;
          end
        end
        ST_PCMP: begin
          if (acc < limit) outside_r <= 1'b1;
          if (acc < limit || pl_r == PIDX_W'(NUM_PLANES - 1)) begin
            occ_r <= 33'({2'b0, globe_r}) - grown_r;
            st_r  <= ST_OCC;
          end else begin
            pl_r <= pl_r + PIDX_W'(1);
            st_r <= ST_PRD;
          end
        end
        ST_OCC: st_r <= ST_OCHK;
        ST_OCHK: begin
          occsq_r <= mul_prod[63:0];
          if (occ_r[32] || occ_r == '0) st_r <= ST_OUT;
          else if (cam_dsq_r > mul_prod[63:0] && dsq_r > mul_prod[63:0]) begin
            wait_r <= 1'b0;
            st_r   <= ST_SQ1;
          end else st_r <= ST_OUT;
        end
        ST_SQ1: begin
          wait_r <= 1'b1;
          if (sq_rsp.done) begin
            t_r    <= {1'b0, sq_rsp.root};
            wait_r <= 1'b0;
            st_r   <= ST_SQ2;
          end
        end
        ST_SQ2: begin
          wait_r <= 1'b1;
          if (sq_rsp.done) begin
            t_r    <= t_r + {1'b0, sq_rsp.root};
            tsq_r  <= '0;
            tb_r   <= '0;
            wait_r <= 1'b0;
            st_r   <= ST_TSQ;
          end
        end
        ST_TSQ: begin
          if (t_r[tb_r]) tsq_r <= tsq_r + prod_bits;
          if (tb_r == 6'd33) begin
            term_r <= 2'd0;
            dacc_clr_r <= 1'b1;
            st_r   <= ST_DIST;
          end else tb_r <= tb_r + 6'd1;
        end
        ST_DIST: begin
          dacc_clr_r <= 1'b0;
          if (term_r == 2'd3) st_r <= ST_HCMP;
          term_r <= term_r + 2'd1;
        end
        ST_HCMP: begin
          hidden_r <= dacc_r > tsq_r;
          st_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_ovalid_r) begin
            res_ovalid_r <= 1'b1;
            res_out_r    <= outside_r;
            res_hid_r    <= hidden_r;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dacc_clr_r) dacc_r <= '0;
    else if (st_r == ST_DIST && term_r != 2'd0) dacc_r <= dacc_r + {62'd0, mul_prod};
  end

  assign out_valid           = res_ovalid_r;
  assign out_outside_frustum = res_out_r;
  assign out_beyond_horizon  = res_hid_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_neg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && neg_r && kind_r) |-> (!outside_r && !hidden_r))
    else $error("negative radius flagged");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ovalid_r && !out_ready) |=> res_ovalid_r) else $error("result dropped");

endmodule

// ----- test/sfhc_cull_checker.sv -----
// ----------------------------------------------------------------------------
// sfhc_cull_checker
// Watches the configuration, item and result channels of the cull core,
// keeps its own plane store and register copy, predicts both flags of every
// sphere test and compares them in order with the results the core hands off.
// ----------------------------------------------------------------------------
module sfhc_cull_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [2:0]  in_plane_index,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_sphere_radius,
  input  logic [63:0] in_center_dist_sq,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_outside_frustum,
  input  logic        out_beyond_horizon,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPL  = sfhc_pkg::NUM_PLANES_DEF;
  localparam int FRAC = sfhc_pkg::NORMAL_FRAC_BITS_DEF;

  typedef struct packed {
    logic outside;
    logic hidden;
  } cull_flags_t;

  logic signed [31:0] pl_nx [NPL];
  logic signed [31:0] pl_ny [NPL];
  logic signed [31:0] pl_nz [NPL];
  logic signed [31:0] pl_off[NPL];
  logic [30:0] globe_r, slack_m;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [63:0] cam_dsq;
  cull_flags_t flags_q[$];

  // Rounded-up integer square root, bit by bit from the top.
  function automatic logic [65:0] root_up(logic [63:0] a);
    logic [65:0] r, c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (66'd1 << b);
      if (c * c <= {2'b00, a}) r = c;
    end
    if (r * r < {2'b00, a}) r = r + 1;
    return r;
  endfunction

  function automatic cull_flags_t cull_predict(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z, logic signed [31:0] rad,
                                               logic [63:0] dsq);
    logic signed [127:0] cx, cy, cz, r, g, grown, lim, acc, occ, occsq, cd, sd, dist_sq;
    logic signed [127:0] nx, ny, nz, off, dx, dy, dz;
    logic [65:0] t;
    logic [131:0] tt;
    cull_flags_t f;
    f = '0;
    cx = x; cy = y; cz = z; r = rad;
    if (r < 0) return f;
    g = slack_m;
    grown = r + g;
    lim = -(grown <<< FRAC);
    for (int i = 0; i < NPL; i++) begin
      nx = pl_nx[i]; ny = pl_ny[i]; nz = pl_nz[i]; off = pl_off[i];
      acc = nx * cx + ny * cy + nz * cz + (off <<< FRAC);
      if (acc < lim) f.outside = 1'b1;
    end
    g = globe_r;
    occ = g - grown;
    if (occ > 0) begin
      occsq = occ * occ;
      cd = cam_dsq;
      sd = dsq;
      if (cd > occsq && sd > occsq) begin
        dx = cx - 128'(cam_x); dy = cy - 128'(cam_y); dz = cz - 128'(cam_z);
        dist_sq = dx * dx + dy * dy + dz * dz;
        t = root_up(64'(cd - occsq)) + root_up(64'(sd - occsq));
        tt = t * t;
        f.hidden = {4'b0, dist_sq} > tt;
      end
    end
    return f;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] cull check: %s", $realtime, what);
    errors++;
  endtask

  // The core's registers: cam_x etc. are signed copies; treat the index by name.
  always @(posedge clk) begin
    cull_flags_t exp_f;
    if (!rst_n) begin
      globe_r <= '0; slack_m <= '0; cam_x <= '0; cam_y <= '0; cam_z <= '0; cam_dsq <= '0;
      flags_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfhc_pkg::REG_GLOBE_MIN_RADIUS: globe_r <= cfg_data[30:0];
          sfhc_pkg::REG_SLACK:            slack_m <= cfg_data[30:0];
          sfhc_pkg::REG_CAMERA_X:         cam_x   <= cfg_data[31:0];
          sfhc_pkg::REG_CAMERA_Y:         cam_y   <= cfg_data[31:0];
          sfhc_pkg::REG_CAMERA_Z:         cam_z   <= cfg_data[31:0];
          sfhc_pkg::REG_CAMERA_DIST_SQ:   cam_dsq <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (!in_kind) begin
          // Drop loads aimed past the last slot.
          if (in_plane_index < NPL) begin
            pl_nx[in_plane_index]  <= in_normal_x;
            pl_ny[in_plane_index]  <= in_normal_y;
            pl_nz[in_plane_index]  <= in_normal_z;
            pl_off[in_plane_index] <= in_plane_offset;
          end
        end else begin
          flags_q.push_back(cull_predict(in_center_x, in_center_y, in_center_z,
                                         in_sphere_radius, in_center_dist_sq));
        end
      end
      if (out_valid && out_ready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          exp_f = flags_q.pop_front();
          if (out_outside_frustum !== exp_f.outside)
            report_mismatch($sformatf("outside_frustum %b, expected %b",
                                      out_outside_frustum, exp_f.outside));
          if (out_beyond_horizon !== exp_f.hidden)
            report_mismatch($sformatf("beyond_horizon %b, expected %b",
                                      out_beyond_horizon, exp_f.hidden));
        end
      end
    end
    pending = flags_q.size();
  end

endmodule

// ----- test/tb_sphere_frustum_horizon_cull_core.sv -----
// ----------------------------------------------------------------------------
// tb_sphere_frustum_horizon_cull_core
// Stimulus and verdict for the sphere frustum / horizon cull core.
// ----------------------------------------------------------------------------
// Loads all five planes, runs a directed set of sphere tests over the corner
// cases (negative radius, occluder collapsed by radius, camera or centre
// inside the occluder, extreme fields, dropped plane loads), then four
// register settings with random items under different idle and stall mixes.
// A separate checker predicts and compares; this module only drives and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_sphere_frustum_horizon_cull_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DSQ_MAX = 64'hC000_0000_0000_0000;
  localparam int DRAIN_CYCLES = 150;  // settle time after the last result

  typedef struct {
    logic        kind;
    logic [2:0]  idx;
    logic [31:0] nx, ny, nz, off, cx, cy, cz, rad;
    logic [63:0] dsq;
  } cull_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic in_kind = 1'b0;
  logic [2:0] in_plane_index = '0;
  logic signed [31:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic signed [31:0] in_plane_offset = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_sphere_radius = '0;
  logic [63:0] in_center_dist_sq = '0;
  logic out_valid, out_ready = 1'b1;
  logic out_outside_frustum, out_beyond_horizon;
  int errors, pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;
  logic in_fire_q = 1'b0, cfg_fire_q = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sphere_frustum_horizon_cull_core dut (.*);

  sfhc_cull_checker chk (.*);

  // Note handshakes at the edge; the driver reads them at the next falling edge.
  always @(posedge clk) begin
    in_fire_q  <= in_valid && in_ready;
    cfg_fire_q <= cfg_valid && cfg_ready;
  end

  // Receiver: one long hold-off on request, otherwise random stalls.
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire_q);
    cfg_valid <= 1'b0;
  endtask

  // Entered and left at a falling edge; valid stays up for the next item.
  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= it.kind;
    in_plane_index   <= it.idx;
    in_normal_x      <= it.nx;
    in_normal_y      <= it.ny;
    in_normal_z      <= it.nz;
    in_plane_offset  <= it.off;
    in_center_x      <= it.cx;
    in_center_y      <= it.cy;
    in_center_z      <= it.cz;
    in_sphere_radius <= it.rad;
    in_center_dist_sq <= it.dsq;
    do @(negedge clk); while (!in_fire_q);
  endtask

  // Hold the sender until every expected result is in, then let the core settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic cull_item_t plane_load(int idx, int nx, int ny, int nz, int off);
    cull_item_t it;
    it = '{default: '0};
    it.idx = 3'(idx);
    it.nx = nx; it.ny = ny; it.nz = nz; it.off = off;
    it.cx = $urandom; it.rad = $urandom;  // junk in unused fields
    return it;
  endfunction

  function automatic cull_item_t sphere(int x, int y, int z, int rad, logic [63:0] dsq);
    cull_item_t it;
    it = '{default: '0};
    it.kind = 1'b1;
    it.cx = x; it.cy = y; it.cz = z; it.rad = rad; it.dsq = dsq;
    it.nx = $urandom; it.off = $urandom;
    return it;
  endfunction

  function automatic logic [63:0] sq3(int x, int y, int z);
    longint a, b, c;
    a = x; b = y; c = z;
    return 64'(a * a + b * b + c * c);
  endfunction

  function automatic int rnd_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic cull_item_t rand_plane();
    return plane_load($urandom_range(4), rnd_signed(1 << 30), rnd_signed(1 << 30),
                      rnd_signed(1 << 30), rnd_signed(12_000_000));
  endfunction

  function automatic cull_item_t rand_sphere();
    int x, y, z;
    x = rnd_signed(9_000_000);
    y = rnd_signed(9_000_000);
    z = rnd_signed(9_000_000);
    return sphere(x, y, z, $urandom_range(200_000), sq3(x, y, z));
  endfunction

  // Anything the fields allow; plane index may point past the store.
  function automatic cull_item_t rand_noise();
    cull_item_t it;
    it.kind = $urandom_range(1);
    it.idx = $urandom_range(7);
    it.nx = $urandom; it.ny = $urandom; it.nz = $urandom; it.off = $urandom;
    it.cx = $urandom; it.cy = $urandom; it.cz = $urandom; it.rad = $urandom;
    it.dsq = {$urandom, $urandom};
    if (it.dsq > DSQ_MAX) it.dsq[62] = 1'b0;
    return it;
  endfunction

  task automatic set_camera(int x, int y, int z, logic [63:0] dsq);
    write_reg(sfhc_pkg::REG_CAMERA_X, 64'(x));
    write_reg(sfhc_pkg::REG_CAMERA_Y, 64'(y));
    write_reg(sfhc_pkg::REG_CAMERA_Z, 64'(z));
    write_reg(sfhc_pkg::REG_CAMERA_DIST_SQ, dsq);
  endtask

  initial begin
    cull_item_t it;
    int x, y, z, pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Globe of earth size, camera a little above it on +z.
    write_reg(sfhc_pkg::REG_GLOBE_MIN_RADIUS, 64'd6_371_000);
    write_reg(sfhc_pkg::REG_SLACK, 64'd10);
    set_camera(0, 0, 7_000_000, sq3(0, 0, 7_000_000));

    // Directed: fill every plane slot, including extreme normals and offsets.
    send_item(plane_load(0, 1 << 30, 0, 0, 10_000_000));
    send_item(plane_load(1, -(1 << 30), 0, 0, 10_000_000));
    send_item(plane_load(2, 0, 1 << 30, 0, 10_000_000));
    send_item(plane_load(3, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(plane_load(4, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(plane_load(4, 0, -(1 << 30), 0, 10_000_000));
    // Loads past the store are dropped.
    send_item(plane_load(5, 32'sh8000_0000, 0, 0, 32'sh8000_0000));
    send_item(plane_load(7, -1, -1, -1, -1));
    // Sphere tests.
    send_item(sphere(0, 0, 0, 0, 0));
    send_item(sphere(0, 0, -6_400_000, 100, sq3(0, 0, -6_400_000)));  // far side: hidden
    send_item(sphere(0, 0, 6_400_000, 100, sq3(0, 0, 6_400_000)));    // near side: visible
    send_item(sphere(20_000_000, 0, 0, 5, sq3(20_000_000, 0, 0)));     // behind a plane
    send_item(sphere(20_000_000, 0, 0, -1, sq3(20_000_000, 0, 0)));    // negative radius
    send_item(sphere(0, 0, -6_400_000, 32'sh8000_0000, sq3(0, 0, -6_400_000)));
    send_item(sphere(0, 0, -6_400_000, 7_000_000, sq3(0, 0, -6_400_000)));  // occluder gone
    send_item(sphere(0, 0, -100, 10, sq3(0, 0, -100)));                 // centre inside
    send_item(sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, DSQ_MAX));
    send_item(sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, DSQ_MAX));
    send_item(sphere(0, 0, -6_400_000, 0, 64'hFFFF_FFFF_FFFF_FFFF & DSQ_MAX));
    drain();
    // Camera inside the occluder.
    set_camera(0, 0, 1000, 64'd1_000_000);
    send_item(sphere(0, 0, -6_400_000, 100, sq3(0, 0, -6_400_000)));
    drain();

    // Random phases, each with its own register setting and idle mix.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(sfhc_pkg::REG_GLOBE_MIN_RADIUS, 64'd6_371_000);
          write_reg(sfhc_pkg::REG_SLACK, 64'($urandom_range(1000)));
          set_camera(4_000_000, -3_000_000, 6_000_000,
                     sq3(4_000_000, -3_000_000, 6_000_000));
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          // Extremes of every register.
          write_reg(sfhc_pkg::REG_GLOBE_MIN_RADIUS, 64'h7FFF_FFFF);
          write_reg(sfhc_pkg::REG_SLACK, 64'h7FFF_FFFF);
          set_camera(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, DSQ_MAX);
          send_idle_pct = 46; recv_stall_pct = 0;
        end
        2: begin
          write_reg(sfhc_pkg::REG_GLOBE_MIN_RADIUS, 64'd0);
          write_reg(sfhc_pkg::REG_SLACK, 64'd0);
          set_camera(0, 0, 0, 64'd0);
          send_idle_pct = 0; recv_stall_pct = 46;
        end
        default: begin
          write_reg(sfhc_pkg::REG_GLOBE_MIN_RADIUS, 64'd1_000_000 + $urandom_range(6_000_000));
          write_reg(sfhc_pkg::REG_SLACK, 64'($urandom_range(50_000)));
          x = rnd_signed(5_000_000); y = rnd_signed(5_000_000); z = 8_000_000;
          set_camera(x, y, z, sq3(x, y, z));
          send_idle_pct = 25; recv_stall_pct = 25;
        end
      endcase
      // Refresh the whole store so no test reads a stale-looking setup.
      for (int p = 0; p < 5; p++) begin
        it = rand_plane();
        it.idx = 3'(p);
        send_item(it);
      end
      // Long receiver hold-off while items keep coming, once.
      if (ph == 0) long_hold_req = 1'b1;
      for (int n = 0; n < 150; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) send_item(rand_sphere());
        else if (pick < 82) send_item(rand_plane());
        else send_item(rand_noise());
        // Mid-phase pause with no idling stretch after it.
        if (n == 75 && ph == 3) begin
          drain();
          send_idle_pct = 0; recv_stall_pct = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("** sphere_frustum_horizon_cull_core: PASSED **");
    end else begin
      $display("** sphere_frustum_horizon_cull_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** sphere_frustum_horizon_cull_core: FAILED **");
    $finish;
  end

endmodule

// ----- sphere_frustum_horizon_cull_core.f -----
sv/sfhc_pkg.sv
sv/sfhc_sqrt.sv
sv/sfhc_mac.sv
sv/sphere_frustum_horizon_cull_core.sv
test/sfhc_cull_checker.sv
test/tb_sphere_frustum_horizon_cull_core.sv
